// ----- rtl/ptt_pkg.sv -----
// Shared types and constants for the periodic/one-shot task timer bank.
package ptt_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int KIND_W    = 2;
  localparam int SLOT_W    = 3;
  localparam int PERIOD_W  = 32;
  localparam int COUNT_W   = 4;

  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd3;

  typedef struct packed {
    logic                tick;
    logic                add;
    logic                del;
    logic                scan;
    logic                emit;
    logic [SLOT_W-1:0]   slot;
    logic                one_shot;
    logic [PERIOD_W-1:0] period;
  } ptt_ctl_t;

  typedef struct packed {
    logic              add_ok;
    logic              del_ok;
    logic              found;
    logic              unload;
    logic              hit;
    logic              once;
    logic [SLOT_W-1:0] slot;
  } ptt_rep_t;

endpackage

// ----- rtl/periodic_oneshot_task_timer_bank.sv -----
// Top level of the task timer bank: command sequencer, slot chain, result register.
//
// Usage:
//   Drive in_kind/in_slot/in_one_shot/in_period and raise start; the command is
//   taken at the clock edge where start is high and busy is low.
//   Tick, add and delete: busy while in the EXEC state; the single result beat
//   is registered onto the out_ ports as EXEC ends, with out_last set.
//   Dispatch: a token walks the slot chain twice, one slot per cycle. The first
//   walk claims ready slots and settles the loaded count, the second emits one
//   beat per claimed slot in ascending order. Busy lasts through both walks,
//   and each beat is registered as the second walk's token passes its slot.
//   With no slot ready a single empty beat follows the first walk.
//   Each beat is valid for exactly one cycle while out_valid is high; the
//   receiver cannot stall, so nothing is held back.
//   Reset (rst_n low, synchronous) unloads every slot and clears the count.
//   Rate is set by the chain walk: one slot per cycle for dispatch.
module periodic_oneshot_task_timer_bank #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptt_pkg::KIND_W-1:0]    in_kind,
  input  logic [ptt_pkg::SLOT_W-1:0]    in_slot,
  input  logic                          in_one_shot,
  input  logic [ptt_pkg::PERIOD_W-1:0]  in_period,
  output logic                          out_valid,
  output logic                          out_has_task,
  output logic [ptt_pkg::SLOT_W-1:0]    out_task_slot,
  output logic                          out_was_one_shot,
  output logic                          out_last,
  output logic [ptt_pkg::COUNT_W-1:0]   out_loaded_count
);
  import ptt_pkg::*;

  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [KIND_W-1:0]   cmd_kind_r;
  logic [SLOT_W-1:0]   cmd_slot_r;
  logic                cmd_os_r;
  logic [PERIOD_W-1:0] cmd_per_r;
  logic                launch_r, launch_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    hits_r, hits_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_has_r, out_has_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_once_r, out_once_nxt;
  logic                out_last_r, out_last_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  logic                accept;
  logic                done;
  logic [SLOTS-1:0]    tok;
  ptt_ctl_t            ctl;
  ptt_rep_t            reps [SLOTS];
  ptt_rep_t            rep_all;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign done   = tok[SLOTS-1];

  always_comb begin
    ctl          = '0;
    ctl.tick     = (state_r == ST_EXEC) && (cmd_kind_r == KIND_TICK);
    ctl.add      = (state_r == ST_EXEC) && (cmd_kind_r == KIND_ADD);
    ctl.del      = (state_r == ST_EXEC) && (cmd_kind_r == KIND_DELETE);
    ctl.scan     = (state_r == ST_SCAN);
    ctl.emit     = (state_r == ST_EMIT);
    ctl.slot     = cmd_slot_r;
    ctl.one_shot = cmd_os_r;
    ctl.period   = cmd_per_r;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic tin;
    if (i == 0) begin : g_head
      assign tin = launch_r;
    end else begin : g_link
      assign tin = tok[i-1];
    end
    ptt_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .tok_in  (tin),
      .tok_out (tok[i]),
      .rep     (reps[i])
    );
  end

  always_comb begin
    rep_all = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rep_all = ptt_rep_t'(rep_all | reps[i]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    total_nxt     = total_r;
    hits_nxt      = hits_r;
    rem_nxt       = rem_r;
    out_valid_nxt = 1'b0;
    out_has_nxt   = 1'b0;
    out_slot_nxt  = '0;
    out_once_nxt  = 1'b0;
    out_last_nxt  = 1'b0;
    out_cnt_nxt   = total_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          hits_nxt = '0;
          if (in_kind == KIND_DISPATCH) begin
            state_nxt  = ST_SCAN;
            launch_nxt = 1'b1;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (rep_all.add_ok) begin
          total_nxt = total_r + CNT_W'(1);
        end
        if (rep_all.del_ok) begin
          total_nxt = total_r - CNT_W'(1);
        end
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_cnt_nxt   = total_nxt;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        if (rep_all.found) begin
          hits_nxt = hits_r + CNT_W'(1);
        end
        if (rep_all.unload) begin
          total_nxt = total_r - CNT_W'(1);
        end
        if (done) begin
          if (hits_r == '0) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            rem_nxt    = hits_r;
            launch_nxt = 1'b1;
            state_nxt  = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (rep_all.hit) begin
          out_valid_nxt = 1'b1;
          out_has_nxt   = 1'b1;
          out_slot_nxt  = rep_all.slot;
          out_once_nxt  = rep_all.once;
          out_last_nxt  = (rem_r == CNT_W'(1));
          rem_nxt       = rem_r - CNT_W'(1);
        end
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      total_r     <= '0;
      hits_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      total_r     <= total_nxt;
      hits_r      <= hits_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind_r <= in_kind;
      cmd_slot_r <= in_slot;
      cmd_os_r   <= in_one_shot;
      cmd_per_r  <= in_period;
    end
    out_has_r  <= out_has_nxt;
    out_slot_r <= out_slot_nxt;
    out_once_r <= out_once_nxt;
    out_last_r <= out_last_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign cnt_ext          = {{COUNT_W{1'b0}}, out_cnt_r};
  assign out_valid        = out_valid_r;
  assign out_has_task     = out_has_r;
  assign out_task_slot    = out_slot_r;
  assign out_was_one_shot = out_once_r;
  assign out_last         = out_last_r;
  assign out_loaded_count = cnt_ext[COUNT_W-1:0];

  a_beat_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a command in flight");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({launch_r, tok}))
    else $error("more than one scan token in the slot chain");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(SLOTS))
    else $error("loaded count exceeds slot count");

  a_emit_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && rep_all.hit) |-> (rem_r != '0))
    else $error("dispatch emits more slots than were claimed");

endmodule

// ----- rtl/ptt_cell.sv -----
// One task slot: countdown, reload period, flags and the scan token stage.
module ptt_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptt_pkg::ptt_ctl_t ctl,
  input  logic              tok_in,
  output logic              tok_out,
  output ptt_pkg::ptt_rep_t rep
);
  import ptt_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);
  localparam bit                REACH   = CELL_IDX < (1 << SLOT_W);

  logic [PERIOD_W-1:0] cd_r, cd_nxt;
  logic [PERIOD_W-1:0] per_r, per_nxt;
  logic [PERIOD_W-1:0] cd_dec;
  logic loaded_r, loaded_nxt;
  logic once_r, once_nxt;
  logic ready_r, ready_nxt;
  logic pend_r, pend_nxt;
  logic tok_r;
  logic match;
  logic live_ready;

  assign match      = REACH && (ctl.slot == MY_SLOT);
  assign cd_dec     = cd_r - 32'd1;
  assign live_ready = loaded_r & ready_r;
  assign tok_out    = tok_r;

  always_comb begin
    cd_nxt     = cd_r;
    per_nxt    = per_r;
    loaded_nxt = loaded_r;
    once_nxt   = once_r;
    ready_nxt  = ready_r;
    pend_nxt   = pend_r;
    if (ctl.tick && loaded_r && (cd_r != '0)) begin
      if (cd_dec == '0) begin
        ready_nxt = 1'b1;
        cd_nxt    = per_r;
      end else begin
        cd_nxt = cd_dec;
      end
    end
    if (ctl.add && match && !loaded_r) begin
      cd_nxt     = ctl.period;
      per_nxt    = ctl.period;
      once_nxt   = ctl.one_shot;
      ready_nxt  = 1'b0;
      loaded_nxt = 1'b1;
    end
    if (ctl.del && match && loaded_r) begin
      loaded_nxt = 1'b0;
      ready_nxt  = 1'b0;
    end
    if (ctl.scan && tok_in) begin
      pend_nxt = live_ready;
      if (live_ready) begin
        ready_nxt = 1'b0;
        if (once_r) begin
          loaded_nxt = 1'b0;
        end
      end
    end
    if (ctl.emit && tok_in) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    rep        = '0;
    rep.add_ok = ctl.add && match && !loaded_r;
    rep.del_ok = ctl.del && match && loaded_r;
    rep.found  = ctl.scan && tok_in && live_ready;
    rep.unload = ctl.scan && tok_in && live_ready && once_r;
    rep.hit    = ctl.emit && tok_in && pend_r;
    rep.once   = ctl.emit && tok_in && pend_r && once_r;
    rep.slot   = (ctl.emit && tok_in && pend_r) ? MY_SLOT : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      once_r   <= 1'b0;
      ready_r  <= 1'b0;
      pend_r   <= 1'b0;
      tok_r    <= 1'b0;
    end else begin
      loaded_r <= loaded_nxt;
      once_r   <= once_nxt;
      ready_r  <= ready_nxt;
      pend_r   <= pend_nxt;
      tok_r    <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    cd_r  <= cd_nxt;
    per_r <= per_nxt;
  end

endmodule

// ----- tb/periodic_oneshot_task_timer_bank_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the task timer bank: directed and random commands, beat scoreboard.
module periodic_oneshot_task_timer_bank_tb;
  import ptt_pkg::*;

  localparam int NSLOT      = SLOTS_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN      = 2 * NSLOT + 6;
  localparam int N_ITEMS    = 270;

  typedef struct packed {
    logic               has_task;
    logic [SLOT_W-1:0]  task_slot;
    logic               was_one_shot;
    logic               last;
    logic [COUNT_W-1:0] loaded_count;
  } task_beat_t;

  class timer_bank_scoreboard;
    logic [PERIOD_W-1:0] countdown [NSLOT];
    logic [PERIOD_W-1:0] reload [NSLOT];
    logic [NSLOT-1:0]    loaded;
    logic [NSLOT-1:0]    once;
    logic [NSLOT-1:0]    ready;
    logic [COUNT_W-1:0]  active;
    task_beat_t          due_q[$];

    function new();
      foreach (countdown[i]) begin
        countdown[i] = '0;
        reload[i]    = '0;
      end
      loaded = '0;
      once   = '0;
      ready  = '0;
      active = '0;
    endfunction

    function void push_beat(logic has, int idx, logic os, logic lst);
      task_beat_t b;
      b.has_task     = has;
      b.task_slot    = idx[SLOT_W-1:0];
      b.was_one_shot = os;
      b.last         = lst;
      b.loaded_count = active;
      due_q.push_back(b);
    endfunction

    function void note_command(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                               logic os, logic [PERIOD_W-1:0] per);
      logic [NSLOT-1:0] hit;
      logic [NSLOT-1:0] gone;
      int n;
      int k;
      hit  = '0;
      gone = '0;
      n    = 0;
      k    = 0;
      case (kind)
        KIND_TICK: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (loaded[i] && countdown[i] != '0) begin
              countdown[i] = countdown[i] - 1'b1;
              if (countdown[i] == '0) begin
                ready[i]     = 1'b1;
                countdown[i] = reload[i];
              end
            end
          end
          push_beat(1'b0, 0, 1'b0, 1'b1);
        end
        KIND_ADD: begin
          if (!loaded[slot]) begin
            countdown[slot] = per;
            reload[slot]    = per;
            once[slot]      = os;
            ready[slot]     = 1'b0;
            loaded[slot]    = 1'b1;
            active          = active + 1'b1;
          end
          push_beat(1'b0, 0, 1'b0, 1'b1);
        end
        KIND_DELETE: begin
          if (loaded[slot]) begin
            loaded[slot] = 1'b0;
            ready[slot]  = 1'b0;
            active       = active - 1'b1;
          end
          push_beat(1'b0, 0, 1'b0, 1'b1);
        end
        default: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (loaded[i] && ready[i]) begin
              hit[i]   = 1'b1;
              ready[i] = 1'b0;
              if (once[i]) begin
                gone[i]   = 1'b1;
                loaded[i] = 1'b0;
                active    = active - 1'b1;
              end
              n++;
            end
          end
          if (n == 0) begin
            push_beat(1'b0, 0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < NSLOT; i++) begin
              if (hit[i]) begin
                push_beat(1'b1, i, gone[i], k == n - 1);
                k++;
              end
            end
          end
        end
      endcase
    endfunction

    function bit check_beat(task_beat_t got, output string why);
      task_beat_t want;
      why = "";
      if (due_q.size() == 0) begin
        why = $sformatf("beat with nothing outstanding (has_task %0b slot %0d)",
                        got.has_task, got.task_slot);
        return 1'b1;
      end
      want = due_q.pop_front();
      if (got.has_task !== want.has_task)
        why = {why, $sformatf(" has_task %0b exp %0b", got.has_task, want.has_task)};
      if (got.task_slot !== want.task_slot)
        why = {why, $sformatf(" task_slot %0d exp %0d", got.task_slot, want.task_slot)};
      if (got.was_one_shot !== want.was_one_shot)
        why = {why, $sformatf(" was_one_shot %0b exp %0b", got.was_one_shot,
                              want.was_one_shot)};
      if (got.last !== want.last)
        why = {why, $sformatf(" last %0b exp %0b", got.last, want.last)};
      if (got.loaded_count !== want.loaded_count)
        why = {why, $sformatf(" loaded_count %0d exp %0d", got.loaded_count,
                              want.loaded_count)};
      return why != "";
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   in_kind;
  logic [SLOT_W-1:0]   in_slot;
  logic                in_one_shot;
  logic [PERIOD_W-1:0] in_period;
  logic                out_valid;
  logic                out_has_task;
  logic [SLOT_W-1:0]   out_task_slot;
  logic                out_was_one_shot;
  logic                out_last;
  logic [COUNT_W-1:0]  out_loaded_count;

  timer_bank_scoreboard sb = new();
  int errors    = 0;
  int idle_cnt  = 0;
  int n_sent    = 0;
  bit no_gaps   = 1'b0;

  periodic_oneshot_task_timer_bank u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_one_shot      (in_one_shot),
    .in_period        (in_period),
    .out_valid        (out_valid),
    .out_has_task     (out_has_task),
    .out_task_slot    (out_task_slot),
    .out_was_one_shot (out_was_one_shot),
    .out_last         (out_last),
    .out_loaded_count (out_loaded_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t: mismatch:%s", $time, msg);
  endtask

  always @(posedge clk) begin : beat_monitor
    string why;
    if (rst_n && out_valid) begin
      if (sb.check_beat({out_has_task, out_task_slot, out_was_one_shot, out_last,
                         out_loaded_count}, why))
        report_mismatch(why);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("periodic_oneshot_task_timer_bank_tb: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic issue(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot, logic os,
                       logic [PERIOD_W-1:0] per, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind     = kind;
    in_slot     = slot;
    in_one_shot = os;
    in_period   = per;
    start       = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(kind, slot, os, per);
    n_sent++;
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $urandom_range(0, 4);
    if (r < 8) return $urandom_range(5, 20);
    return $urandom;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 35) return KIND_TICK;
    if (r < 55) return KIND_DISPATCH;
    if (r < 85) return KIND_ADD;
    return KIND_DELETE;
  endfunction

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_kind     = KIND_TICK;
    in_slot     = '0;
    in_one_shot = 1'b0;
    in_period   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: ignored add/delete, zero and full periods, ready held across ticks
    issue(KIND_ADD, 3'd0, 1'b0, 32'd1, 0);
    issue(KIND_ADD, 3'd1, 1'b1, 32'd0, 0);
    issue(KIND_ADD, 3'd7, 1'b1, 32'd2, 1);
    issue(KIND_ADD, 3'd3, 1'b0, 32'hFFFF_FFFF, 0);
    issue(KIND_ADD, 3'd0, 1'b1, 32'd5, 0);
    issue(KIND_DELETE, 3'd5, 1'b0, 32'd0, 2);
    issue(KIND_DISPATCH, 3'd0, 1'b0, 32'd0, 0);
    issue(KIND_TICK, 3'd0, 1'b0, 32'd0, 0);
    issue(KIND_DISPATCH, 3'd0, 1'b0, 32'd0, 0);
    issue(KIND_TICK, 3'd0, 1'b0, 32'd0, 0);
    issue(KIND_TICK, 3'd0, 1'b0, 32'd0, 3);
    issue(KIND_DISPATCH, 3'd0, 1'b0, 32'd0, 0);
    issue(KIND_ADD, 3'd2, 1'b0, 32'd1, 0);
    issue(KIND_TICK, 3'd0, 1'b0, 32'd0, 0);
    issue(KIND_DELETE, 3'd2, 1'b0, 32'd0, 0);
    issue(KIND_DISPATCH, 3'd0, 1'b0, 32'd0, 0);
    issue(KIND_DELETE, 3'd3, 1'b0, 32'd0, 0);
    issue(KIND_DELETE, 3'd0, 1'b0, 32'd0, 1);
    issue(KIND_DELETE, 3'd1, 1'b0, 32'd0, 0);
    issue(KIND_ADD, 3'd6, 1'b1, 32'h8000_0000, 0);
    issue(KIND_DELETE, 3'd6, 1'b0, 32'd0, 0);
    issue(KIND_DISPATCH, 3'd0, 1'b0, 32'd0, 0);

    while (n_sent < N_ITEMS) begin
      if (n_sent % 40 < 11) no_gaps = ($urandom_range(3) == 0);
      if ($urandom_range(99) < 8) begin
        // offer every slot a short-period add, tick twice, then fire a dispatch
        for (int s = 0; s < NSLOT; s++)
          issue(KIND_ADD, s[SLOT_W-1:0], 1'($urandom_range(1)), $urandom_range(1, 2),
                pick_gap());
        issue(KIND_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)), $urandom, pick_gap());
        issue(KIND_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)), $urandom, pick_gap());
        issue(KIND_DISPATCH, 3'($urandom_range(7)), 1'($urandom_range(1)), $urandom,
              pick_gap());
      end else begin
        issue(pick_kind(), 3'($urandom_range(7)), 1'($urandom_range(1)), pick_period(),
              pick_gap());
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0) begin
      $display("periodic_oneshot_task_timer_bank_tb: clean");
    end else begin
      $display("periodic_oneshot_task_timer_bank_tb: errors");
    end
    $finish;
  end

endmodule
